// ----- sv/running_mean_filter_assert.svh -----
// Assertion macros for the running mean filter.
`ifndef RUNNING_MEAN_FILTER_ASSERT_SVH
`define RUNNING_MEAN_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rmf_pkg.sv -----
// Shared constants, types and helper functions of the running mean filter.
package rmf_pkg;

	localparam int MAX_WINDOW = 1024;
	localparam int SAMPLE_W   = 16;
	localparam int MEAN_W     = 16;
	localparam int WIN_W      = 11;
	localparam int WIN_RESET  = 100;
	localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W      = SAMPLE_W + CNT_W;
	localparam int MAG_W      = SUM_W - 1;
	localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [MAG_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [MEAN_W-1:0] quotient;
	} div_rsp_t;

	// Map the window register to 1..MAX_WINDOW.
	function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] w);
		logic [CNT_W-1:0] r;
		if (w == '0) begin
			r = CNT_W'(1);
		end else if (int'(w) > MAX_WINDOW) begin
			r = CNT_W'(MAX_WINDOW);
		end else begin
			r = CNT_W'(int'(w));
		end
		return r;
	endfunction

	// Slot that lies age entries behind newest, wrapping around the history.
	function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] newest,
			input logic [CNT_W-1:0] age);
		logic [SLOT_W-1:0] r;
		if (int'(age) > int'(newest)) begin
			r = SLOT_W'(int'(newest) + MAX_WINDOW - int'(age));
		end else begin
			r = SLOT_W'(int'(newest) - int'(age));
		end
		return r;
	endfunction

endpackage

// ----- sv/running_mean_filter.sv -----
// Running mean filter: moving average of signed samples over a programmable window.
// Usage:
//   s_axis carries one 16-bit signed sample per transfer; m_axis returns one
//   16-bit signed mean per sample, the sum of the newest window samples divided
//   by window, truncated toward zero. cfg writes the 11-bit window (1..1024;
//   zero acts as 1, larger values as 1024); write it only while the block is idle.
// Operation:
//   While the window matches the one used for the previous sample, the sum is
//   slid by adding the new sample and dropping the oldest; the sum is then
//   divided by the window in the 26-step restoring divider.
//   After a window change the sum is rebuilt by reading the history once per
//   entry before it is divided.
//   s_axis_tready is low until the result is parked in the output register.
// Reset:
//   arst_n clears the window to 100, the running sum and the fill count;
//   history slots not yet written read as zero through the fill count.
// Stall:
//   A result waits in the output register while m_axis_tready is low; the next
//   result waits in the divider and s_axis_tready stays low until it moves on.
module running_mean_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rmf_pkg::WIN_W-1:0]   cfg_data,       // [10:0] window
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [rmf_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [15:0] sample
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [rmf_pkg::MEAN_W-1:0]  m_axis_tdata    // [15:0] mean
);

	import rmf_pkg::*;

`include "running_mean_filter_assert.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_DROP_RD,
		S_DROP_ADD,
		S_FULL_WR,
		S_SUM,
		S_DIV_GO,
		S_DIV_WAIT,
		S_HOLD
	} state_t;

	state_t                     state_q;
	logic [WIN_W-1:0]           window_q;
	logic [SLOT_W-1:0]          newest_q;
	logic [CNT_W-1:0]           fill_q;
	logic [CNT_W-1:0]           fill_old_q;
	logic [CNT_W-1:0]           win_q;
	logic [CNT_W-1:0]           wused_q;
	logic [CNT_W-1:0]           age_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SUM_W-1:0]    acc_q;
	logic                       pend_s1;
	logic                       ok_s1;
	logic                       out_valid_q;
	logic [MEAN_W-1:0]          out_data_q;

	logic                       in_xfer;
	logic                       out_free;
	logic                       out_load;
	logic [CNT_W-1:0]           w_eff;
	logic                       ram_we;
	logic [SLOT_W-1:0]          ram_raddr;
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic signed [SUM_W-1:0]    rd_ext;
	logic signed [SUM_W-1:0]    drop_ext;
	logic signed [SUM_W-1:0]    sum_abs;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = out_free &&
	                       ((state_q == S_DIV_WAIT && div_rsp.done) || state_q == S_HOLD);
	assign w_eff         = eff_window(window_q);

	assign ram_we    = (state_q == S_DROP_ADD) || (state_q == S_FULL_WR);
	assign ram_raddr = (state_q == S_DROP_RD) ? slot_back(newest_q, win_q)
	                                          : slot_back(newest_q, age_q);

	rmf_hist_ram #(
		.DEPTH(MAX_WINDOW),
		.WIDTH(SAMPLE_W)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(newest_q),
		.wdata(sample_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_ext   = SUM_W'($signed(ram_rdata));
	// Slots older than the fill count were never written: count them as zero.
	assign drop_ext = ok_s1 ? rd_ext : '0;
	assign sum_abs  = sum_q[SUM_W-1] ? -sum_q : sum_q;

	assign div_req.start    = (state_q == S_DIV_GO);
	assign div_req.neg      = sum_q[SUM_W-1];
	assign div_req.dividend = sum_abs[MAG_W-1:0];
	assign div_req.divisor  = win_q;

	rmf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			window_q    <= WIN_W'(WIN_RESET);
			newest_q    <= '0;
			fill_q      <= '0;
			fill_old_q  <= '0;
			win_q       <= CNT_W'(1);
			wused_q     <= eff_window(WIN_W'(WIN_RESET));
			age_q       <= '0;
			sample_q    <= '0;
			sum_q       <= '0;
			acc_q       <= '0;
			pend_s1     <= 1'b0;
			ok_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_valid) begin
				window_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= div_rsp.quotient;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						sample_q   <= s_axis_tdata;
						newest_q   <= (int'(newest_q) == MAX_WINDOW - 1) ? '0
						              : newest_q + SLOT_W'(1);
						fill_old_q <= fill_q;
						if (fill_q != CNT_W'(MAX_WINDOW)) begin
							fill_q <= fill_q + CNT_W'(1);
						end
						win_q   <= w_eff;
						wused_q <= w_eff;
						// Same window as last time: slide the sum, else rebuild it.
						state_q <= (w_eff == wused_q) ? S_DROP_RD : S_FULL_WR;
					end
				end
				S_DROP_RD: begin
					ok_s1   <= win_q <= fill_old_q;
					state_q <= S_DROP_ADD;
				end
				S_DROP_ADD: begin
					sum_q   <= sum_q + SUM_W'(sample_q) - drop_ext;
					state_q <= S_DIV_GO;
				end
				S_FULL_WR: begin
					age_q   <= '0;
					acc_q   <= '0;
					pend_s1 <= 1'b0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (age_q != win_q) begin
						pend_s1 <= 1'b1;
						ok_s1   <= age_q <= fill_old_q;
						age_q   <= age_q + CNT_W'(1);
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1) begin
						acc_q <= acc_q + drop_ext;
					end
					if (age_q == win_q && !pend_s1) begin
						sum_q   <= acc_q;
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						state_q <= out_free ? S_IDLE : S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`RMF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_xfer, !s_axis_tready, "busy input")
	`RMF_ASSERT_NOW(a_done_in_wait, clk, arst_n, div_rsp.done, state_q == S_DIV_WAIT, "early done")
	`RMF_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CNT_W'(MAX_WINDOW), "fill overrun")
	`RMF_ASSERT_NOW(a_sum_age, clk, arst_n, state_q == S_SUM, age_q <= win_q, "sum overrun")

endmodule

// ----- sv/rmf_hist_ram.sv -----
// Sample history memory: one write port, one read port with registered data.
module rmf_hist_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/rmf_div.sv -----
// Restoring divider: one quotient bit per cycle, signed result truncated toward zero.
module rmf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rmf_pkg::div_req_t req,
	output rmf_pkg::div_rsp_t rsp
);

	import rmf_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     dvs_q;
	logic [MAG_W-1:0]     quo_q;
	logic [CNT_W:0]       trial;
	logic [CNT_W:0]       diff;
	logic                 fits;
	logic [MEAN_W-1:0]    quo_lo;

	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				neg_q  <= req.neg;
				cnt_q  <= DIV_CNT_W'(MAG_W);
				rem_q  <= '0;
				dvs_q  <= req.divisor;
				quo_q  <= req.dividend;
			end else if (busy_q) begin
				rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], fits};
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quo_lo       = quo_q[MEAN_W-1:0];
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -quo_lo : quo_lo;

endmodule
